[design/bclru_pkg.sv]
// Shared types, constants and helpers for the block cache LRU lookup.
// No dependencies; imported by every other file of the block.
package bclru_pkg;

  localparam int SLOT_COUNT     = 16;
  localparam int COUNT_BITS     = 8;
  localparam int SLOT_BITS      = $clog2(SLOT_COUNT);
  localparam int DEV_BITS       = 8;
  localparam int BLK_BITS       = 32;
  localparam int IDX_BITS       = 4;
  localparam int ID_CMP_BITS    = (SLOT_BITS > IDX_BITS) ? SLOT_BITS : IDX_BITS;

  typedef logic [SLOT_BITS-1:0]  slot_id_t;
  typedef logic [SLOT_BITS-1:0]  pos_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [IDX_BITS-1:0]   idx_t;

  localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    OP_GET  = 2'd0,
    OP_REL  = 2'd1,
    OP_MARK = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_MISS    = 3'd1,
    ST_NOFREE  = 3'd2,
    ST_OVF     = 3'd3,
    ST_REL     = 3'd4,
    ST_REL_ERR = 3'd5,
    ST_MARKED  = 3'd6
  } status_e;

  // One LRU stack entry; position in the chain is the recency rank.
  typedef struct packed {
    slot_id_t              slot;
    logic [DEV_BITS-1:0]   dev;
    logic [BLK_BITS-1:0]   blk;
    count_t                cnt;
    logic                  valid;
  } cell_data_t;

  typedef struct packed {
    logic tag_hit;
    logic free;
    logic idx_hit;
    logic cnt_max;
    logic cnt_one;
    logic valid;
  } cell_flags_t;

  typedef struct packed {
    logic load_front;
    logic shift;
    logic inc;
    logic dec;
    logic retag;
    logic set_valid;
  } cell_cmd_t;

  typedef struct packed {
    logic    valid;
    status_e status;
    idx_t    slot;
    logic    fill;
  } result_t;

  function automatic idx_t out_slot(slot_id_t id);
    logic [SLOT_BITS+IDX_BITS-1:0] w;
    w = {{IDX_BITS{1'b0}}, id};
    return w[IDX_BITS-1:0];
  endfunction

  function automatic logic [ID_CMP_BITS-1:0] cmp_id(slot_id_t id);
    logic [ID_CMP_BITS+SLOT_BITS-1:0] w;
    w = {{ID_CMP_BITS{1'b0}}, id};
    return w[ID_CMP_BITS-1:0];
  endfunction

  function automatic logic [ID_CMP_BITS-1:0] cmp_idx(idx_t idx);
    logic [ID_CMP_BITS+IDX_BITS-1:0] w;
    w = {{ID_CMP_BITS{1'b0}}, idx};
    return w[ID_CMP_BITS-1:0];
  endfunction

endpackage

[design/bclru_cell.sv]
// One LRU stack cell: holds a slot's tags, count and valid flag, compares
// them against the request, and loads from its more recent neighbor on a shift.
// Depends on bclru_pkg.
module bclru_cell import bclru_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  slot_id_t    reset_slot_i,
  input  logic        eval_i,
  input  logic [DEV_BITS-1:0] dev_i,
  input  logic [BLK_BITS-1:0] blk_i,
  input  idx_t        idx_i,
  input  cell_cmd_t   cmd_i,
  input  cell_data_t  nbr_i,
  input  cell_data_t  front_i,
  output cell_data_t  data_o,
  output cell_flags_t flags_o
);

  cell_data_t  data_q, data_d;
  cell_flags_t flags_q, flags_d;

  always_comb begin
    flags_d.tag_hit = (data_q.dev == dev_i) && (data_q.blk == blk_i);
    flags_d.free    = (data_q.cnt == '0);
    flags_d.idx_hit = (cmp_id(data_q.slot) == cmp_idx(idx_i));
    flags_d.cnt_max = (data_q.cnt == COUNT_MAX);
    flags_d.cnt_one = (data_q.cnt == count_t'(1));
    flags_d.valid   = data_q.valid;
  end

  always_comb begin
    data_d = data_q;
    if (cmd_i.load_front) begin
      data_d = front_i;
    end else if (cmd_i.shift) begin
      data_d = nbr_i;
    end else begin
      if (cmd_i.inc) data_d.cnt = data_q.cnt + count_t'(1);
      if (cmd_i.dec) data_d.cnt = data_q.cnt - count_t'(1);
      if (cmd_i.retag) begin
        data_d.dev   = dev_i;
        data_d.blk   = blk_i;
        data_d.cnt   = count_t'(1);
        data_d.valid = 1'b0;
      end
      if (cmd_i.set_valid) data_d.valid = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q.slot  <= reset_slot_i;
      data_q.dev   <= '0;
      data_q.blk   <= '0;
      data_q.cnt   <= '0;
      data_q.valid <= 1'b0;
      flags_q      <= '0;
    end else begin
      data_q <= data_d;
      if (eval_i) flags_q <= flags_d;
    end
  end

  assign data_o  = data_q;
  assign flags_o = flags_q;

endmodule

[design/bclru_pick.sv]
// Decision logic: priority picks over the registered cell flags, the per-cell
// update commands and the result word. Depends on bclru_pkg.
module bclru_pick import bclru_pkg::*; (
  input  logic        apply_i,
  input  op_e         op_i,
  input  idx_t        idx_i,
  input  cell_flags_t flags_i [SLOT_COUNT],
  input  cell_data_t  data_i  [SLOT_COUNT],
  output cell_cmd_t   cmd_o   [SLOT_COUNT],
  output cell_data_t  front_o,
  output result_t     res_o
);

  logic hit_any, free_any, idx_any;
  pos_t hit_pos, free_pos, idx_pos;

  // Hit: most recent match. Miss: least recent free cell.
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    idx_any  = 1'b0;
    hit_pos  = '0;
    free_pos = '0;
    idx_pos  = '0;
    for (int p = SLOT_COUNT - 1; p >= 0; p--) begin
      if (flags_i[p].tag_hit) begin
        hit_any = 1'b1;
        hit_pos = pos_t'(p);
      end
    end
    for (int p = 0; p < SLOT_COUNT; p++) begin
      if (flags_i[p].free) begin
        free_any = 1'b1;
        free_pos = pos_t'(p);
      end
      if (flags_i[p].idx_hit) begin
        idx_any = 1'b1;
        idx_pos = pos_t'(p);
      end
    end
  end

  always_comb begin
    front_o     = data_i[idx_pos];
    front_o.cnt = '0;
  end

  always_comb begin
    for (int p = 0; p < SLOT_COUNT; p++) cmd_o[p] = '0;
    res_o.valid  = apply_i && (op_i != OP_NONE);
    res_o.status = ST_NOFREE;
    res_o.slot   = idx_i;
    res_o.fill   = 1'b0;
    case (op_i)
      OP_GET: begin
        res_o.slot = '0;
        if (hit_any) begin
          res_o.slot = out_slot(data_i[hit_pos].slot);
          if (flags_i[hit_pos].cnt_max) begin
            res_o.status = ST_OVF;
          end else begin
            res_o.status        = ST_HIT;
            res_o.fill          = !flags_i[hit_pos].valid;
            cmd_o[hit_pos].inc  = apply_i;
          end
        end else if (free_any) begin
          res_o.status          = ST_MISS;
          res_o.slot            = out_slot(data_i[free_pos].slot);
          res_o.fill            = 1'b1;
          cmd_o[free_pos].retag = apply_i;
        end
      end
      OP_REL: begin
        if (!idx_any || flags_i[idx_pos].free) begin
          res_o.status = ST_REL_ERR;
        end else begin
          res_o.status = ST_REL;
          if (flags_i[idx_pos].cnt_one) begin
            // last reference: move to the front, more recent cells slide down
            cmd_o[0].load_front = apply_i;
            for (int p = 1; p < SLOT_COUNT; p++) begin
              cmd_o[p].shift = apply_i && (pos_t'(p) <= idx_pos);
            end
          end else begin
            cmd_o[idx_pos].dec = apply_i;
          end
        end
      end
      OP_MARK: begin
        res_o.status              = ST_MARKED;
        cmd_o[idx_pos].set_valid  = apply_i && idx_any;
      end
      default: begin
        res_o.valid = 1'b0;
      end
    endcase
  end

endmodule

[design/block_cache_lru_lookup.sv]
// Top level of the block cache LRU lookup: request registers, the chain of
// LRU stack cells and the decision logic. Depends on bclru_pkg, bclru_cell
// and bclru_pick.
//
// Usage notes:
// - Request word: opcode_i, device_id_i, block_number_i, slot_index_i. It is
//   taken at a rising edge where start is high and busy is low.
// - Result word: status_o, granted_slot_o, needs_fill_o, valid for exactly one
//   cycle while done_o is high. The receiver cannot stall; it must take it.
// - Opcode three is dropped and gives no result word.
// - Timing: after the accept edge comes a compare cycle (busy high), in which
//   every cell checks its tags, count and slot id, then an update cycle that
//   picks the slot and writes the cells. done_o is high in the cycle after.
//   A new request can be taken in the update cycle but not in the compare
//   cycle, since the compare flags must see the previous update.
// - The cells form an LRU stack: cell 0 is most recent. A last release moves
//   the slot to cell 0 and the more recent cells each take their neighbor.
// - Reset: all tags, counts and valid flags clear, cell p holds slot
//   SLOT_COUNT-1-p. The block is ready in the first cycle after reset.
module block_cache_lru_lookup import bclru_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          opcode_i,
  input  logic [DEV_BITS-1:0] device_id_i,
  input  logic [BLK_BITS-1:0] block_number_i,
  input  idx_t                slot_index_i,
  output logic                done_o,
  output logic [2:0]          status_o,
  output idx_t                granted_slot_o,
  output logic                needs_fill_o
);

  logic                eval_q, apply_q;
  op_e                 op_q;
  logic [DEV_BITS-1:0] dev_q;
  logic [BLK_BITS-1:0] blk_q;
  idx_t                idx_q;

  cell_flags_t flags   [SLOT_COUNT];
  cell_data_t  data    [SLOT_COUNT];
  cell_cmd_t   cmd     [SLOT_COUNT];
  cell_data_t  front;
  result_t     res;

  logic        done_q;
  status_e     status_q;
  idx_t        slot_q;
  logic        fill_q;

  logic        accept;

  assign busy   = eval_q;
  assign accept = start && !eval_q;

  // Request registers; hold through the compare and update cycles.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_q  <= 1'b0;
      apply_q <= 1'b0;
    end else begin
      eval_q  <= accept;
      apply_q <= eval_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(opcode_i);
      dev_q <= device_id_i;
      blk_q <= block_number_i;
      idx_q <= slot_index_i;
    end
  end

  for (genvar p = 0; p < SLOT_COUNT; p++) begin : g_cell
    bclru_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .reset_slot_i (slot_id_t'(SLOT_COUNT - 1 - p)),
      .eval_i       (eval_q),
      .dev_i        (dev_q),
      .blk_i        (blk_q),
      .idx_i        (idx_q),
      .cmd_i        (cmd[p]),
      .nbr_i        ((p == 0) ? front : data[(p == 0) ? 0 : p - 1]),
      .front_i      (front),
      .data_o       (data[p]),
      .flags_o      (flags[p])
    );
  end

  bclru_pick u_pick (
    .apply_i (apply_q),
    .op_i    (op_q),
    .idx_i   (idx_q),
    .flags_i (flags),
    .data_i  (data),
    .cmd_o   (cmd),
    .front_o (front),
    .res_o   (res)
  );

  // Output register: result word shows for one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      status_q <= res.status;
      slot_q   <= res.slot;
      fill_q   <= res.fill;
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign granted_slot_o = slot_q;
  assign needs_fill_o   = fill_q;

  // Slot ids in the chain stay unique, so at most one cell answers an index.
  logic [SLOT_COUNT-1:0] idx_hit_vec;
  always_comb begin
    for (int p = 0; p < SLOT_COUNT; p++) idx_hit_vec[p] = flags[p].idx_hit;
  end

  a_busy_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy) else $error("compare cycle lasted more than one cycle");

  a_apply_follows_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_q |=> apply_q) else $error("update cycle missing after compare");

  a_done_from_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(apply_q)) else $error("result without an update cycle");

  a_idx_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apply_q |-> $onehot0(idx_hit_vec)) else $error("slot id held by two cells");

  a_miss_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_MISS) |-> needs_fill_o)
    else $error("recycled slot not flagged for fill");

endmodule

[tb/block_cache_lru_lookup_tb.sv]
// Self-checking testbench for block_cache_lru_lookup: directed requests, then random
// request sequences, scored against a behavioral LRU cache kept in the bench; known
// rows use typed-in results. Depends on bclru_pkg and block_cache_lru_lookup RTL.
module block_cache_lru_lookup_tb;
  import bclru_pkg::*;

  typedef logic [DEV_BITS-1:0] dev_t;
  typedef logic [BLK_BITS-1:0] blk_t;

  // One result word as the block reports it.
  typedef struct packed {
    status_e status;
    idx_t    slot;
    logic    fill;
  } outcome_t;

  // One line of the directed script; known rows carry their result typed in.
  typedef struct packed {
    op_e      op;
    dev_t     dev;
    blk_t     blk;
    idx_t     idx;
    logic     known;
    outcome_t want;
  } plan_row_t;

  localparam int RANDOM_WORDS = 1900;
  localparam int IDLE_PCT     = 22;
  localparam int QUIET_WORDS  = 300;   // back-to-back stretch, no sender gaps

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic [1:0] opcode_i;
  dev_t device_id_i;
  blk_t block_number_i;
  idx_t slot_index_i;
  logic done_o;
  logic [2:0] status_o;
  idx_t granted_slot_o;
  logic needs_fill_o;

  block_cache_lru_lookup DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .device_id_i    (device_id_i),
    .block_number_i (block_number_i),
    .slot_index_i   (slot_index_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .granted_slot_o (granted_slot_o),
    .needs_fill_o   (needs_fill_o)
  );

  // Shadow copy of the cache. lru_rank 0 is the most recently used slot.
  dev_t tag_dev  [SLOT_COUNT];
  blk_t tag_blk  [SLOT_COUNT];
  int   ref_cnt  [SLOT_COUNT];
  bit   filled   [SLOT_COUNT];
  int   lru_rank [SLOT_COUNT];

  outcome_t  pending_outcomes[$];   // results owed by the block, oldest first
  plan_row_t plan_rows[$];

  int words_sent;
  int results_checked;
  int mismatches;
  int status_tally[8];
  bit idle_on;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("** block_cache_lru_lookup: FAILED **");
    $finish;
  end

  // Applies one request to the shadow cache. Returns 0 when the request
  // yields no result word (opcode three).
  function automatic bit cache_outcome(input op_e op, input dev_t dev, input blk_t blk,
                                       input idx_t idx, output outcome_t res);
    int  i;
    int  pick;
    int  r;
    bit  found;
    res   = '0;
    found = 1'b0;
    pick  = 0;
    case (op)
      OP_GET: begin
        // Tag match: the most recent matching slot wins.
        for (i = 0; i < SLOT_COUNT; i++) begin
          if (tag_dev[i] == dev && tag_blk[i] == blk &&
              (!found || lru_rank[i] < lru_rank[pick])) begin
            found = 1'b1;
            pick  = i;
          end
        end
        if (found) begin
          res.slot = idx_t'(pick);
          if (ref_cnt[pick] >= int'(COUNT_MAX)) begin
            res.status = ST_OVF;
          end else begin
            ref_cnt[pick]++;
            res.status = ST_HIT;
            res.fill   = !filled[pick];
          end
          return 1'b1;
        end
        // Miss: recycle the least recent slot nobody holds.
        for (i = 0; i < SLOT_COUNT; i++) begin
          if (ref_cnt[i] == 0 && (!found || lru_rank[i] > lru_rank[pick])) begin
            found = 1'b1;
            pick  = i;
          end
        end
        if (!found) begin
          res.status = ST_NOFREE;
          return 1'b1;
        end
        tag_dev[pick] = dev;
        tag_blk[pick] = blk;
        ref_cnt[pick] = 1;
        filled[pick]  = 1'b0;
        res.status    = ST_MISS;
        res.slot      = idx_t'(pick);
        res.fill      = 1'b1;
        return 1'b1;
      end
      OP_REL: begin
        res.slot = idx;
        if (int'(idx) >= SLOT_COUNT || ref_cnt[idx] == 0) begin
          res.status = ST_REL_ERR;
          return 1'b1;
        end
        ref_cnt[idx]--;
        if (ref_cnt[idx] == 0) begin
          // Last reference gone: slot jumps to the front, the ones ahead slide back.
          r = lru_rank[idx];
          for (i = 0; i < SLOT_COUNT; i++) begin
            if (lru_rank[i] < r) lru_rank[i]++;
          end
          lru_rank[idx] = 0;
        end
        res.status = ST_REL;
        return 1'b1;
      end
      OP_MARK: begin
        if (int'(idx) < SLOT_COUNT) filled[idx] = 1'b1;
        res.status = ST_MARKED;
        res.slot   = idx;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Random slot that currently holds references, or -1.
  function automatic int held_slot();
    int hold[$];
    int i;
    for (i = 0; i < SLOT_COUNT; i++) begin
      if (ref_cnt[i] > 0) hold.push_back(i);
    end
    if (hold.size() == 0) return -1;
    return hold[$urandom_range(0, hold.size() - 1)];
  endfunction

  task automatic plan(op_e op, dev_t dev, blk_t blk, idx_t idx);
    plan_rows.push_back('{op, dev, blk, idx, 1'b0, '0});
  endtask

  task automatic plan_known(op_e op, dev_t dev, blk_t blk, idx_t idx,
                            status_e st, idx_t slot, logic fill);
    plan_rows.push_back('{op, dev, blk, idx, 1'b1, '{st, slot, fill}});
  endtask

  // Drives one request word from a falling edge, holds it until the block
  // takes it, scores it and returns at the next falling edge. start is only
  // written once per time step, so a back-to-back word keeps it high.
  task automatic send_word(op_e op, dev_t dev, blk_t blk, idx_t idx,
                           logic known, outcome_t want_in);
    outcome_t predicted;
    if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    start          <= 1'b1;
    opcode_i       <= op;
    device_id_i    <= dev;
    block_number_i <= blk;
    slot_index_i   <= idx;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (cache_outcome(op, dev, blk, idx, predicted))
      pending_outcomes.push_back(known ? want_in : predicted);
    if (op != OP_NONE) words_sent++;
    @(negedge clk_i);
  endtask

  // Unused fields get random filler so every input bit toggles.
  task automatic issue_get(dev_t dev, blk_t blk);
    send_word(OP_GET, dev, blk, idx_t'($urandom), 1'b0, '0);
  endtask

  task automatic issue_slot(op_e op, idx_t idx);
    send_word(op, dev_t'($urandom), blk_t'($urandom), idx, 1'b0, '0);
  endtask

  // Release every held slot down to zero, starting at a random slot.
  task automatic drain_all();
    int base;
    int k;
    int s;
    base = $urandom_range(0, SLOT_COUNT - 1);
    for (k = 0; k < SLOT_COUNT; k++) begin
      s = (base + k) % SLOT_COUNT;
      while (ref_cnt[s] > 0) begin
        if ($urandom_range(0, 9) == 0) issue_slot(OP_MARK, idx_t'(s));
        issue_slot(OP_REL, idx_t'(s));
      end
    end
  endtask

  // Result scoreboard: done_o is a one-cycle strobe, sampled at the edge
  // that closes its cycle.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result word: status %0d slot %0d fill %0d",
               status_o, granted_slot_o, needs_fill_o);
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        results_checked++;
        status_tally[status_o]++;
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
        if (granted_slot_o !== want.slot) begin
          $error("granted_slot: expected %0d, got %0d", want.slot, granted_slot_o);
          mismatches++;
        end
        if (needs_fill_o !== want.fill) begin
          $error("needs_fill: expected %0d, got %0d", want.fill, needs_fill_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int   i;
    int   k;
    int   n;
    int   j;
    int   r;
    int   s;
    int   pick;
    int   target;
    int   quiet_from;
    dev_t pool_dev [4];
    blk_t pool_blk [4];
    dev_t near_dev;
    blk_t near_blk;
    dev_t sat_dev;
    blk_t sat_blk;

    rst_ni         <= 1'b0;
    start          <= 1'b0;
    opcode_i       <= OP_GET;
    device_id_i    <= '0;
    block_number_i <= '0;
    slot_index_i   <= '0;
    idle_on         = 1'b1;

    // Shadow cache at reset: empty tags, slot i at rank SLOT_COUNT-1-i.
    for (i = 0; i < SLOT_COUNT; i++) begin
      tag_dev[i]  = '0;
      tag_blk[i]  = '0;
      ref_cnt[i]  = 0;
      filled[i]   = 1'b0;
      lru_rank[i] = SLOT_COUNT - 1 - i;
    end

    // Directed script. After reset every slot carries tag 0/0 and slot 15
    // is the most recent, slot 0 the least recent.
    plan_known(OP_GET,  8'h00, 32'h0000_0000, 4'd3,  ST_HIT,     4'd15, 1'b1);
    plan_known(OP_MARK, 8'h00, 32'h0000_0000, 4'd15, ST_MARKED,  4'd15, 1'b0);
    plan_known(OP_GET,  8'h00, 32'h0000_0000, 4'd0,  ST_HIT,     4'd15, 1'b0);
    plan_known(OP_GET,  8'hff, 32'hffff_ffff, 4'd15, ST_MISS,    4'd0,  1'b1);
    plan      (OP_GET,  8'hff, 32'hffff_ffff, 4'd9);
    plan      (OP_REL,  8'h3c, 32'h1234_5678, 4'd0);
    plan      (OP_REL,  8'hc3, 32'h8765_4321, 4'd0);   // last ref: slot 0 to front
    plan_known(OP_REL,  8'hff, 32'hffff_ffff, 4'd0,  ST_REL_ERR, 4'd0,  1'b0);
    plan_known(OP_REL,  8'h00, 32'h0000_0000, 4'd7,  ST_REL_ERR, 4'd7,  1'b0);
    plan      (OP_GET,  8'ha5, 32'h5a5a_5a5a, 4'd5);   // recycles the new LRU slot
    plan      (OP_GET,  8'hff, 32'hffff_ffff, 4'd10);  // hit on an unheld slot
    plan_known(OP_MARK, 8'h5a, 32'ha5a5_a5a5, 4'd0,  ST_MARKED,  4'd0,  1'b0);
    plan      (OP_REL,  8'h00, 32'h0000_0000, 4'd0);
    plan      (OP_GET,  8'hff, 32'hffff_ffff, 4'd0);   // valid flag survives release
    plan      (OP_NONE, 8'h81, 32'h7fff_fffe, 4'd6);   // dropped, no result
    plan      (OP_GET,  8'h00, 32'h0000_0000, 4'd15);
    plan_known(OP_MARK, 8'h00, 32'h0000_0000, 4'd0,  ST_MARKED,  4'd0,  1'b0);
    plan      (OP_REL,  8'h00, 32'h0000_0000, 4'd15);
    plan      (OP_GET,  8'h00, 32'h0000_0001, 4'd11);  // one bit off the reset tag
    plan      (OP_GET,  8'h01, 32'h0000_0000, 4'd12);
    plan      (OP_GET,  8'h80, 32'h8000_0000, 4'd4);
    plan      (OP_NONE, 8'hff, 32'hffff_ffff, 4'd15);
    plan_known(OP_MARK, 8'hff, 32'hffff_ffff, 4'd15, ST_MARKED,  4'd15, 1'b0);
    plan      (OP_REL,  8'h00, 32'h0000_0000, 4'd15);
    plan      (OP_REL,  8'h00, 32'h0000_0000, 4'd15);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < plan_rows.size(); k++)
      send_word(plan_rows[k].op, plan_rows[k].dev, plan_rows[k].blk, plan_rows[k].idx,
                plan_rows[k].known, plan_rows[k].want);

    target     = words_sent + RANDOM_WORDS;
    quiet_from = words_sent + 600;

    // Saturate one tag: a miss, hits up to the count ceiling, then two
    // rejected gets, then give every reference back.
    sat_dev = dev_t'($urandom);
    sat_blk = blk_t'($urandom);
    repeat (int'(COUNT_MAX) + 2) issue_get(sat_dev, sat_blk);
    drain_all();

    while (words_sent < target) begin
      idle_on = (words_sent < quiet_from) || (words_sent >= quiet_from + QUIET_WORDS);
      r = $urandom_range(0, 99);
      if (r < 35) begin
        // Working set: a few tags fetched, held, filled and released.
        for (j = 0; j < 4; j++) begin
          k = $urandom_range(0, 9);
          s = $urandom_range(0, SLOT_COUNT - 1);
          if (k < 3) begin
            pool_dev[j] = tag_dev[s];
            pool_blk[j] = tag_blk[s];
          end else if (k == 3) begin
            pool_dev[j] = '0;
            pool_blk[j] = '0;
          end else begin
            pool_dev[j] = dev_t'($urandom);
            pool_blk[j] = blk_t'($urandom);
          end
        end
        n = $urandom_range(10, 30);
        repeat (n) begin
          k    = $urandom_range(0, 99);
          pick = held_slot();
          j    = $urandom_range(0, 3);
          if (k < 50 || pick < 0) issue_get(pool_dev[j], pool_blk[j]);
          else if (k < 80)        issue_slot(OP_REL, idx_t'(pick));
          else                    issue_slot(OP_MARK, idx_t'(pick));
        end
      end else if (r < 47) begin
        // Fill every slot and go past it to hit the no-free case.
        repeat ($urandom_range(17, 20)) issue_get(dev_t'($urandom), blk_t'($urandom));
        repeat ($urandom_range(0, 4)) begin
          pick = held_slot();
          if (pick >= 0) issue_slot(OP_MARK, idx_t'(pick));
        end
        drain_all();
      end else if (r < 62) begin
        // Releases and marks on arbitrary slots, many of them errors.
        repeat ($urandom_range(3, 8))
          issue_slot($urandom_range(0, 1) ? OP_REL : OP_MARK, idx_t'($urandom));
      end else if (r < 78) begin
        // Noise, opcode three included.
        repeat ($urandom_range(4, 12))
          send_word(op_e'($urandom_range(0, 3)), dev_t'($urandom), blk_t'($urandom),
                    idx_t'($urandom), 1'b0, '0);
      end else if (r < 88) begin
        // Near miss: a resident tag with one bit flipped, then the real tag.
        s        = $urandom_range(0, SLOT_COUNT - 1);
        near_dev = tag_dev[s];
        near_blk = tag_blk[s];
        if ($urandom_range(0, 1))
          issue_get(near_dev ^ (dev_t'(1) << $urandom_range(0, DEV_BITS - 1)), near_blk);
        else
          issue_get(near_dev, near_blk ^ (blk_t'(1) << $urandom_range(0, BLK_BITS - 1)));
        issue_get(near_dev, near_blk);
        pick = held_slot();
        if (pick >= 0) issue_slot(OP_REL, idx_t'(pick));
      end else begin
        drain_all();
      end
    end

    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Run: %0d request words, %0d result words checked, %0d mismatches.",
             words_sent, results_checked, mismatches);
    $display("Seen: hit %0d, miss %0d, no free %0d, overflow %0d, release %0d, %s %0d, mark %0d",
             status_tally[ST_HIT], status_tally[ST_MISS], status_tally[ST_NOFREE],
             status_tally[ST_OVF], status_tally[ST_REL], "release error",
             status_tally[ST_REL_ERR], status_tally[ST_MARKED]);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("** block_cache_lru_lookup: PASSED **");
    end else begin
      $display("** block_cache_lru_lookup: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
design/bclru_pkg.sv
design/bclru_cell.sv
design/bclru_pick.sv
design/block_cache_lru_lookup.sv
tb/block_cache_lru_lookup_tb.sv
